// File: rtl/core/slk_pkg.sv
`timescale 1ns / 1ps

package slk_pkg;

   localparam int QUEUE_DEPTH      = 8;
   localparam int QUEUE_AW         = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW         = $clog2(QUEUE_DEPTH + 1);
   localparam int ITEM_QUEUE_DEPTH = 2;
   localparam int ITEM_QUEUE_AW    = $clog2(ITEM_QUEUE_DEPTH);
   localparam int ITEM_QUEUE_CW    = $clog2(ITEM_QUEUE_DEPTH + 1);

   localparam logic [1:0] FUNC_ENQUEUE = 2'd0;
   localparam logic [1:0] FUNC_STATUS  = 2'd1;
   localparam logic [1:0] FUNC_TICK    = 2'd2;

   localparam logic [1:0] TX_NONE  = 2'd0;
   localparam logic [1:0] TX_NEW   = 2'd1;
   localparam logic [1:0] TX_RETRY = 2'd2;
   localparam logic [1:0] TX_POLL  = 2'd3;

   localparam logic [3:0] POLL_CODE = 4'd0;

   localparam logic [1:0] CSR_ACK_TIMEOUT   = 2'd0;
   localparam logic [1:0] CSR_MAX_RETRIES   = 2'd1;
   localparam logic [1:0] CSR_POLL_INTERVAL = 2'd2;
   localparam logic [1:0] CSR_LINK_TIMEOUT  = 2'd3;

   localparam logic [15:0] ACK_TIMEOUT_RESET   = 16'd200;
   localparam logic [3:0]  MAX_RETRIES_RESET   = 4'd3;
   localparam logic [15:0] POLL_INTERVAL_RESET = 16'd100;
   localparam logic [15:0] LINK_TIMEOUT_RESET  = 16'd1000;

   typedef struct packed {
      logic is_enqueue;
      logic is_status;
      logic is_tick;
   } class_type;

   typedef struct packed {
      class_type          cls;
      logic [31:0]        time_ms;
      logic [3:0]         command_code;
      logic               side;
      logic signed [31:0] reference_milligrams;
      logic [7:0]         status_sequence;
      logic [7:0]         ack_sequence;
   } item_type;

   typedef struct packed {
      logic [3:0]         code;
      logic               side;
      logic signed [31:0] ref_mg;
   } entry_type;

   typedef struct packed {
      logic               accepted;
      logic               fresh;
      logic               acked;
      logic               cmd_dropped;
      logic [1:0]         tx_kind;
      logic [7:0]         tx_sequence;
      logic [3:0]         tx_command;
      logic               tx_side;
      logic signed [31:0] tx_reference;
      logic [3:0]         retry_number;
      logic               link_up;
   } result_type;

endpackage

// File: rtl/core/slk_req_if.sv
`timescale 1ns / 1ps

interface slk_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic [31:0]        time_ms;
   logic [3:0]         command_code;
   logic               side;
   logic signed [31:0] reference_milligrams;
   logic [7:0]         status_sequence;
   logic [7:0]         ack_sequence;

   modport source (output valid, func, time_ms, command_code, side, reference_milligrams,
                   status_sequence, ack_sequence, input ready);
   modport sink (input valid, func, time_ms, command_code, side, reference_milligrams,
                 status_sequence, ack_sequence, output ready);
endinterface

// File: rtl/core/slk_rsp_if.sv
`timescale 1ns / 1ps

interface slk_rsp_if;
   logic               valid;
   logic               ready;
   logic               accepted;
   logic               fresh;
   logic               acked;
   logic               cmd_dropped;
   logic [1:0]         tx_kind;
   logic [7:0]         tx_sequence;
   logic [3:0]         tx_command;
   logic               tx_side;
   logic signed [31:0] tx_reference;
   logic [3:0]         retry_number;
   logic               link_up;

   modport source (output valid, accepted, fresh, acked, cmd_dropped, tx_kind,
                   tx_sequence, tx_command, tx_side, tx_reference, retry_number, link_up,
                   input ready);
   modport sink (input valid, accepted, fresh, acked, cmd_dropped, tx_kind,
                 tx_sequence, tx_command, tx_side, tx_reference, retry_number, link_up,
                 output ready);
endinterface

// File: rtl/core/slk_csr_if.sv
`timescale 1ns / 1ps

interface slk_csr_if;
   logic        valid;
   logic        ready;
   logic [1:0]  index;
   logic [15:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/core/stop_and_wait_command_link.sv
`timescale 1ns / 1ps

// Host side of a stop-and-wait command link: enqueue, status and tick items each give one
// result. An accepted item lands in a two-entry item queue, and the back end executes the
// head item once its result register is free; one item per cycle is sustained while
// rsp_ch.ready stays high, set by the back end's single execute step per item. Either
// side may stall without stalling the other until the item queue is full. Configuration
// writes are always taken (csr_ch.ready is tied high) and take effect on the next item.
module stop_and_wait_command_link (
   input  logic        clock,
   input  logic        reset,
   slk_req_if.sink     req_ch,
   slk_rsp_if.source   rsp_ch,
   slk_csr_if.sink     csr_ch
);

   logic               item_valid;
   slk_pkg::item_type  item_data;
   logic               item_pop;

   slk_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .item_valid (item_valid),
      .item_data  (item_data),
      .item_pop   (item_pop)
   );

   slk_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item_data  (item_data),
      .item_pop   (item_pop),
      .csr_ch     (csr_ch),
      .rsp_ch     (rsp_ch)
   );

endmodule

// File: rtl/core/slk_front.sv
`timescale 1ns / 1ps

module slk_front (
   input  logic                clock,
   input  logic                reset,
   slk_req_if.sink             req_ch,
   output logic                item_valid,
   output slk_pkg::item_type   item_data,
   input  logic                item_pop
);

   slk_pkg::item_type                         items_ff [slk_pkg::ITEM_QUEUE_DEPTH];
   logic [slk_pkg::ITEM_QUEUE_AW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [slk_pkg::ITEM_QUEUE_AW-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [slk_pkg::ITEM_QUEUE_CW-1:0]         count_ff, count_in;
   slk_pkg::item_type                         incoming;
   logic                                      push;
   logic                                      pop;

   assign req_ch.ready = (count_ff < slk_pkg::ITEM_QUEUE_CW'(slk_pkg::ITEM_QUEUE_DEPTH));
   assign push         = req_ch.valid && req_ch.ready;
   assign item_valid   = (count_ff != '0);
   assign pop          = item_pop && item_valid;
   assign item_data    = items_ff[rd_ptr_ff];

   always_comb begin
      incoming.cls.is_enqueue       = (req_ch.func == slk_pkg::FUNC_ENQUEUE);
      incoming.cls.is_status        = (req_ch.func == slk_pkg::FUNC_STATUS);
      incoming.cls.is_tick          = (req_ch.func == slk_pkg::FUNC_TICK);
      incoming.time_ms              = req_ch.time_ms;
      incoming.command_code         = req_ch.command_code;
      incoming.side                 = req_ch.side;
      incoming.reference_milligrams = req_ch.reference_milligrams;
      incoming.status_sequence      = req_ch.status_sequence;
      incoming.ack_sequence         = req_ch.ack_sequence;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == slk_pkg::ITEM_QUEUE_AW'(slk_pkg::ITEM_QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == slk_pkg::ITEM_QUEUE_AW'(slk_pkg::ITEM_QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         items_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule

// File: rtl/core/slk_back.sv
`timescale 1ns / 1ps

module slk_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  slk_pkg::item_type   item_data,
   output logic                item_pop,
   slk_csr_if.sink             csr_ch,
   slk_rsp_if.source           rsp_ch
);

   logic [15:0] ack_timeout_ff;
   logic [3:0]  max_retries_ff;
   logic [15:0] poll_interval_ff;
   logic [15:0] link_timeout_ff;

   slk_pkg::entry_type                  qmem [slk_pkg::QUEUE_DEPTH];
   logic [slk_pkg::QUEUE_AW-1:0]        head_ff, head_in;
   logic [slk_pkg::QUEUE_AW-1:0]        tail_ff, tail_in;
   logic [slk_pkg::QUEUE_CW-1:0]        count_ff, count_in;
   logic                                in_flight_ff, in_flight_in;
   slk_pkg::entry_type                  ife_ff, ife_in;
   logic [7:0]                          if_seq_ff, if_seq_in;
   logic [3:0]                          retry_ff, retry_in;
   logic [31:0]                         sent_ff, sent_in;
   logic [7:0]                          seq_ff, seq_in;
   logic [31:0]                         last_poll_ff, last_poll_in;
   logic                                polled_ff, polled_in;
   logic                                have_ff, have_in;
   logic [7:0]                          last_sseq_ff, last_sseq_in;
   logic [31:0]                         last_valid_ff, last_valid_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   slk_pkg::result_type                 rsp_ff;
   slk_pkg::result_type                 res;
   logic                                go;
   logic                                qwrite;
   logic                                carry_on;
   logic [31:0]                         t;
   logic [31:0]                         ack_age;
   logic [31:0]                         poll_age;
   logic [31:0]                         link_age;
   slk_pkg::entry_type                  new_entry;

   assign csr_ch.ready = 1'b1;
   assign go           = item_valid && (!rsp_valid_ff || rsp_ch.ready);
   assign item_pop     = go;
   assign t            = item_data.time_ms;
   assign ack_age      = t - sent_ff;
   assign poll_age     = t - last_poll_ff;
   assign link_age     = t - last_valid_in;

   always_comb begin
      new_entry.code   = item_data.command_code;
      new_entry.side   = item_data.side;
      new_entry.ref_mg = item_data.reference_milligrams;
   end

   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      in_flight_in  = in_flight_ff;
      ife_in        = ife_ff;
      if_seq_in     = if_seq_ff;
      retry_in      = retry_ff;
      sent_in       = sent_ff;
      seq_in        = seq_ff;
      last_poll_in  = last_poll_ff;
      polled_in     = polled_ff;
      have_in       = have_ff;
      last_sseq_in  = last_sseq_ff;
      last_valid_in = last_valid_ff;
      qwrite        = 1'b0;
      carry_on      = 1'b0;
      res           = '0;

      if (item_data.cls.is_enqueue) begin
         if (count_ff < slk_pkg::QUEUE_CW'(slk_pkg::QUEUE_DEPTH)) begin
            qwrite       = 1'b1;
            tail_in      = (tail_ff == slk_pkg::QUEUE_AW'(slk_pkg::QUEUE_DEPTH - 1)) ?
                           '0 : tail_ff + 1'b1;
            count_in     = count_ff + 1'b1;
            res.accepted = 1'b1;
         end
      end else if (item_data.cls.is_status) begin
         res.fresh     = !have_ff || (item_data.status_sequence != last_sseq_ff);
         last_sseq_in  = item_data.status_sequence;
         have_in       = 1'b1;
         last_valid_in = t;
         if (in_flight_ff && (item_data.ack_sequence == if_seq_ff)) begin
            in_flight_in = 1'b0;
            retry_in     = '0;
            res.acked    = 1'b1;
         end
      end else if (item_data.cls.is_tick) begin
         if (in_flight_ff) begin
            if (ack_age >= {16'd0, ack_timeout_ff}) begin
               if (retry_ff >= max_retries_ff) begin
                  res.cmd_dropped = 1'b1;
                  in_flight_in    = 1'b0;
                  retry_in        = '0;
                  carry_on        = 1'b1;
               end else begin
                  retry_in         = retry_ff + 1'b1;
                  sent_in          = t;
                  last_poll_in     = t;
                  polled_in        = 1'b1;
                  res.tx_kind      = slk_pkg::TX_RETRY;
                  res.tx_sequence  = if_seq_ff;
                  res.tx_command   = ife_ff.code;
                  res.tx_side      = ife_ff.side;
                  res.tx_reference = ife_ff.ref_mg;
               end
            end
         end else begin
            carry_on = 1'b1;
         end
         if (carry_on) begin
            if (count_ff != '0) begin
               ife_in           = qmem[head_ff];
               head_in          = (head_ff == slk_pkg::QUEUE_AW'(slk_pkg::QUEUE_DEPTH - 1)) ?
                                  '0 : head_ff + 1'b1;
               count_in         = count_ff - 1'b1;
               seq_in           = seq_ff + 1'b1;
               if_seq_in        = seq_ff + 1'b1;
               in_flight_in     = 1'b1;
               retry_in         = '0;
               sent_in          = t;
               last_poll_in     = t;
               polled_in        = 1'b1;
               res.tx_kind      = slk_pkg::TX_NEW;
               res.tx_sequence  = seq_ff + 1'b1;
               res.tx_command   = qmem[head_ff].code;
               res.tx_side      = qmem[head_ff].side;
               res.tx_reference = qmem[head_ff].ref_mg;
            end else if (!polled_ff || (poll_age >= {16'd0, poll_interval_ff})) begin
               seq_in           = seq_ff + 1'b1;
               last_poll_in     = t;
               polled_in        = 1'b1;
               res.tx_kind      = slk_pkg::TX_POLL;
               res.tx_sequence  = seq_ff + 1'b1;
               res.tx_command   = slk_pkg::POLL_CODE;
               res.tx_side      = 1'b0;
               res.tx_reference = '0;
            end
         end
      end

      res.retry_number = retry_in;
      res.link_up      = have_in && (link_age <= {16'd0, link_timeout_ff});
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ack_timeout_ff   <= slk_pkg::ACK_TIMEOUT_RESET;
         max_retries_ff   <= slk_pkg::MAX_RETRIES_RESET;
         poll_interval_ff <= slk_pkg::POLL_INTERVAL_RESET;
         link_timeout_ff  <= slk_pkg::LINK_TIMEOUT_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            slk_pkg::CSR_ACK_TIMEOUT:   ack_timeout_ff   <= csr_ch.data;
            slk_pkg::CSR_MAX_RETRIES:   max_retries_ff   <= csr_ch.data[3:0];
            slk_pkg::CSR_POLL_INTERVAL: poll_interval_ff <= csr_ch.data;
            slk_pkg::CSR_LINK_TIMEOUT:  link_timeout_ff  <= csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= '0;
         in_flight_ff  <= 1'b0;
         ife_ff        <= '0;
         if_seq_ff     <= '0;
         retry_ff      <= '0;
         sent_ff       <= '0;
         seq_ff        <= '0;
         last_poll_ff  <= '0;
         polled_ff     <= 1'b0;
         have_ff       <= 1'b0;
         last_sseq_ff  <= '0;
         last_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (go) begin
            head_ff       <= head_in;
            tail_ff       <= tail_in;
            count_ff      <= count_in;
            in_flight_ff  <= in_flight_in;
            ife_ff        <= ife_in;
            if_seq_ff     <= if_seq_in;
            retry_ff      <= retry_in;
            sent_ff       <= sent_in;
            seq_ff        <= seq_in;
            last_poll_ff  <= last_poll_in;
            polled_ff     <= polled_in;
            have_ff       <= have_in;
            last_sseq_ff  <= last_sseq_in;
            last_valid_ff <= last_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         rsp_ff <= res;
      end
      if (go && qwrite) begin
         qmem[tail_ff] <= new_entry;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.accepted     = rsp_ff.accepted;
   assign rsp_ch.fresh        = rsp_ff.fresh;
   assign rsp_ch.acked        = rsp_ff.acked;
   assign rsp_ch.cmd_dropped  = rsp_ff.cmd_dropped;
   assign rsp_ch.tx_kind      = rsp_ff.tx_kind;
   assign rsp_ch.tx_sequence  = rsp_ff.tx_sequence;
   assign rsp_ch.tx_command   = rsp_ff.tx_command;
   assign rsp_ch.tx_side      = rsp_ff.tx_side;
   assign rsp_ch.tx_reference = rsp_ff.tx_reference;
   assign rsp_ch.retry_number = rsp_ff.retry_number;
   assign rsp_ch.link_up      = rsp_ff.link_up;

endmodule

// File: bench/slk_result_checker.sv
`timescale 1ns / 1ps

module slk_result_checker
   import slk_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   slk_req_if         req_ch,
   slk_rsp_if         rsp_ch,
   slk_csr_if         csr_ch,
   output int         mismatches,
   output int         outstanding,
   output logic [7:0] flight_sequence
);

   logic [15:0] ack_timeout;
   logic [3:0]  retry_limit;
   logic [15:0] poll_interval;
   logic [15:0] link_timeout;

   entry_type   command_ring [QUEUE_DEPTH];
   int unsigned ring_head;
   int unsigned ring_tail;
   int unsigned ring_count;
   logic        busy;
   entry_type   busy_entry;
   logic [7:0]  busy_sequence;
   logic [3:0]  retries;
   logic [31:0] sent_at;
   logic [7:0]  next_sequence;
   logic [31:0] polled_at;
   logic        polled_ever;
   logic        status_seen;
   logic [7:0]  status_sequence_seen;
   logic [31:0] status_at;

   result_type  pending_results [$];
   int          errors = 0;

   function automatic void load_tx(inout result_type r, input logic [1:0] kind,
                                   input logic [7:0] seq_no, input entry_type e,
                                   input logic [31:0] now);
      r.tx_kind      = kind;
      r.tx_sequence  = seq_no;
      r.tx_command   = e.code;
      r.tx_side      = e.side;
      r.tx_reference = e.ref_mg;
      polled_at      = now;
      polled_ever    = 1'b1;
   endfunction

   function automatic void service_tick(input logic [31:0] now, inout result_type r);
      entry_type   poll_entry;
      logic [31:0] since_sent;
      logic [31:0] since_poll;
      poll_entry = '{code: POLL_CODE, side: 1'b0, ref_mg: 32'sd0};
      since_sent = now - sent_at;
      since_poll = now - polled_at;
      if (busy) begin
         if (since_sent < {16'd0, ack_timeout}) return;
         if (retries >= retry_limit) begin
            r.cmd_dropped = 1'b1;
            busy          = 1'b0;
            retries       = 4'd0;
         end else begin
            retries = retries + 4'd1;
            sent_at = now;
            load_tx(r, TX_RETRY, busy_sequence, busy_entry, now);
            return;
         end
      end
      if (ring_count > 0) begin
         busy_entry    = command_ring[ring_head];
         ring_head     = (ring_head + 1) % QUEUE_DEPTH;
         ring_count    = ring_count - 1;
         next_sequence = next_sequence + 8'd1;
         busy_sequence = next_sequence;
         busy          = 1'b1;
         retries       = 4'd0;
         sent_at       = now;
         load_tx(r, TX_NEW, busy_sequence, busy_entry, now);
         return;
      end
      if (polled_ever && since_poll < {16'd0, poll_interval}) return;
      next_sequence = next_sequence + 8'd1;
      load_tx(r, TX_POLL, next_sequence, poll_entry, now);
   endfunction

   function automatic result_type apply_item(input logic [1:0] func, input logic [31:0] now,
                                             input logic [3:0] code, input logic side,
                                             input logic signed [31:0] mg,
                                             input logic [7:0] sseq, input logic [7:0] aseq);
      result_type  r;
      logic [31:0] age;
      r = '0;
      case (func)
         FUNC_ENQUEUE: begin
            if (ring_count < QUEUE_DEPTH) begin
               command_ring[ring_tail] = '{code: code, side: side, ref_mg: mg};
               ring_tail  = (ring_tail + 1) % QUEUE_DEPTH;
               ring_count = ring_count + 1;
               r.accepted = 1'b1;
            end
         end
         FUNC_STATUS: begin
            r.fresh              = !status_seen || sseq != status_sequence_seen;
            status_sequence_seen = sseq;
            status_seen          = 1'b1;
            status_at            = now;
            if (busy && aseq == busy_sequence) begin
               busy    = 1'b0;
               retries = 4'd0;
               r.acked = 1'b1;
            end
         end
         FUNC_TICK: begin
            service_tick(now, r);
         end
         default: ;
      endcase
      age            = now - status_at;
      r.retry_number = retries;
      r.link_up      = status_seen && age <= {16'd0, link_timeout};
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         if (errors < 10) $display("mismatch on %s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endfunction

   always @(posedge clock) begin
      result_type expected_result;
      result_type actual_result;
      if (reset) begin
         ack_timeout          = ACK_TIMEOUT_RESET;
         retry_limit          = MAX_RETRIES_RESET;
         poll_interval        = POLL_INTERVAL_RESET;
         link_timeout         = LINK_TIMEOUT_RESET;
         ring_head            = 0;
         ring_tail            = 0;
         ring_count           = 0;
         busy                 = 1'b0;
         busy_entry           = '0;
         busy_sequence        = 8'd0;
         retries              = 4'd0;
         sent_at              = 32'd0;
         next_sequence        = 8'd0;
         polled_at            = 32'd0;
         polled_ever          = 1'b0;
         status_seen          = 1'b0;
         status_sequence_seen = 8'd0;
         status_at            = 32'd0;
         pending_results.delete();
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            case (csr_ch.index)
               CSR_ACK_TIMEOUT:   ack_timeout   = csr_ch.data;
               CSR_MAX_RETRIES:   retry_limit   = csr_ch.data[3:0];
               CSR_POLL_INTERVAL: poll_interval = csr_ch.data;
               CSR_LINK_TIMEOUT:  link_timeout  = csr_ch.data;
               default: ;
            endcase
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            actual_result = '{accepted: rsp_ch.accepted, fresh: rsp_ch.fresh,
                              acked: rsp_ch.acked, cmd_dropped: rsp_ch.cmd_dropped,
                              tx_kind: rsp_ch.tx_kind, tx_sequence: rsp_ch.tx_sequence,
                              tx_command: rsp_ch.tx_command, tx_side: rsp_ch.tx_side,
                              tx_reference: rsp_ch.tx_reference,
                              retry_number: rsp_ch.retry_number, link_up: rsp_ch.link_up};
            if (pending_results.size() == 0) begin
               if (errors < 10) $display("result with nothing expected: got %h", actual_result);
               errors++;
            end else begin
               expected_result = pending_results.pop_front();
               check_field("accepted", expected_result.accepted, actual_result.accepted);
               check_field("fresh", expected_result.fresh, actual_result.fresh);
               check_field("acked", expected_result.acked, actual_result.acked);
               check_field("cmd_dropped", expected_result.cmd_dropped,
                           actual_result.cmd_dropped);
               check_field("tx_kind", expected_result.tx_kind, actual_result.tx_kind);
               check_field("tx_sequence", expected_result.tx_sequence,
                           actual_result.tx_sequence);
               check_field("tx_command", expected_result.tx_command, actual_result.tx_command);
               check_field("tx_side", expected_result.tx_side, actual_result.tx_side);
               check_field("tx_reference", expected_result.tx_reference,
                           actual_result.tx_reference);
               check_field("retry_number", expected_result.retry_number,
                           actual_result.retry_number);
               check_field("link_up", expected_result.link_up, actual_result.link_up);
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            pending_results.push_back(apply_item(req_ch.func, req_ch.time_ms,
                                                 req_ch.command_code, req_ch.side,
                                                 req_ch.reference_milligrams,
                                                 req_ch.status_sequence, req_ch.ack_sequence));
         end
      end
      mismatches      <= errors;
      outstanding     <= pending_results.size();
      flight_sequence <= busy_sequence;
   end

endmodule

// File: bench/stop_and_wait_command_link_tb.sv
`timescale 1ns / 1ps

module stop_and_wait_command_link_tb;
   import slk_pkg::*;

   localparam int         IDLE_PERCENT    = 21;
   localparam int         STALL_LIMIT     = 1000;
   localparam int         PHASES          = 12;
   localparam int         ITEMS_PER_PHASE = 157;
   localparam int         HOLD_CYCLES     = 80;
   localparam logic [1:0] FUNC_UNUSED     = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   int          mismatches;
   int          outstanding;
   logic [7:0]  flight_sequence;
   logic        calm = 1'b0;
   int          hold_tickets = 0;
   int          holds_served = 0;
   int          hold_left = 0;
   int          quiet_cycles = 0;

   logic [31:0] now_ms;
   logic [7:0]  last_status;
   logic [1:0]  func_sel;
   logic [7:0]  sseq;
   logic [7:0]  aseq;
   logic [15:0] ack_cfg;
   logic [3:0]  retry_cfg;
   logic [15:0] poll_cfg;
   logic [15:0] link_cfg;
   int          pick;

   slk_req_if req_ch();
   slk_rsp_if rsp_ch();
   slk_csr_if csr_ch();

   stop_and_wait_command_link u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   slk_result_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_ch          (req_ch),
      .rsp_ch          (rsp_ch),
      .csr_ch          (csr_ch),
      .mismatches      (mismatches),
      .outstanding     (outstanding),
      .flight_sequence (flight_sequence)
   );

   always #1 clock = ~clock;

   // hold the result side off for a stretch whenever the source asks
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_tickets != holds_served) begin
         holds_served <= hold_tickets;
         hold_left    <= HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left    <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic offer(input logic [1:0] func, input logic [31:0] at_ms,
                        input logic [3:0] code, input logic side,
                        input logic signed [31:0] mg, input logic [7:0] status_no,
                        input logic [7:0] ack_no);
      while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid                <= 1'b1;
      req_ch.func                 <= func;
      req_ch.time_ms              <= at_ms;
      req_ch.command_code         <= code;
      req_ch.side                 <= side;
      req_ch.reference_milligrams <= mg;
      req_ch.status_sequence      <= status_no;
      req_ch.ack_sequence         <= ack_no;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic configure(input logic [15:0] ack_ms, input logic [3:0] retry_cap,
                            input logic [15:0] poll_ms, input logic [15:0] link_ms);
      logic [1:0]  index_of [4];
      logic [15:0] value_of [4];
      index_of = '{CSR_ACK_TIMEOUT, CSR_MAX_RETRIES, CSR_POLL_INTERVAL, CSR_LINK_TIMEOUT};
      value_of = '{ack_ms, {12'd0, retry_cap}, poll_ms, link_ms};
      drain();
      for (int i = 0; i < 4; i++) begin
         csr_ch.valid <= 1'b1;
         csr_ch.index <= index_of[i];
         csr_ch.data  <= value_of[i];
         do @(posedge clock); while (!csr_ch.ready);
      end
      csr_ch.valid <= 1'b0;
   endtask

   initial begin
      req_ch.valid                <= 1'b0;
      req_ch.func                 <= FUNC_ENQUEUE;
      req_ch.time_ms              <= 32'd0;
      req_ch.command_code         <= 4'd0;
      req_ch.side                 <= 1'b0;
      req_ch.reference_milligrams <= 32'sd0;
      req_ch.status_sequence      <= 8'd0;
      req_ch.ack_sequence         <= 8'd0;
      csr_ch.valid                <= 1'b0;
      csr_ch.index                <= CSR_ACK_TIMEOUT;
      csr_ch.data                 <= 16'd0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      offer(FUNC_TICK, 32'd0, 4'd0, 1'b0, 32'sd0, 8'd0, 8'd0);
      offer(FUNC_UNUSED, 32'd3, 4'd15, 1'b1, -32'sd1, 8'hFF, 8'hFF);
      offer(FUNC_STATUS, 32'd10, 4'd0, 1'b0, 32'sd0, 8'd0, 8'd0);
      offer(FUNC_STATUS, 32'd11, 4'd0, 1'b0, 32'sd0, 8'd0, 8'd0);
      offer(FUNC_STATUS, 32'd12, 4'd0, 1'b0, 32'sd0, 8'hFF, 8'hFF);
      offer(FUNC_ENQUEUE, 32'd13, 4'd15, 1'b1, 32'sh7FFFFFFF, 8'd0, 8'd0);
      offer(FUNC_ENQUEUE, 32'd13, 4'd0, 1'b0, 32'sh80000000, 8'd0, 8'd0);
      offer(FUNC_ENQUEUE, 32'd13, 4'd5, 1'b1, -32'sd1, 8'd0, 8'd0);
      offer(FUNC_ENQUEUE, 32'd13, 4'd10, 1'b0, 32'sd0, 8'd0, 8'd0);
      offer(FUNC_ENQUEUE, 32'd14, 4'd1, 1'b1, 32'sd12345, 8'd0, 8'd0);
      offer(FUNC_ENQUEUE, 32'd14, 4'd2, 1'b0, -32'sd54321, 8'd0, 8'd0);
      offer(FUNC_ENQUEUE, 32'd14, 4'd3, 1'b1, 32'sh55555555, 8'd0, 8'd0);
      offer(FUNC_ENQUEUE, 32'd15, 4'd12, 1'b0, 32'shAAAAAAAA, 8'd0, 8'd0);
      offer(FUNC_ENQUEUE, 32'd15, 4'd7, 1'b1, 32'sd99, 8'd0, 8'd0);
      offer(FUNC_TICK, 32'd20, 4'd0, 1'b0, 32'sd0, 8'd0, 8'd0);
      offer(FUNC_TICK, 32'd219, 4'd0, 1'b0, 32'sd0, 8'd0, 8'd0);
      offer(FUNC_TICK, 32'd220, 4'd0, 1'b0, 32'sd0, 8'd0, 8'd0);
      offer(FUNC_STATUS, 32'd230, 4'd0, 1'b0, 32'sd0, 8'd1, 8'd0);
      offer(FUNC_STATUS, 32'd231, 4'd0, 1'b0, 32'sd0, 8'd2, flight_sequence);
      offer(FUNC_TICK, 32'd232, 4'd0, 1'b0, 32'sd0, 8'd0, 8'd0);
      offer(FUNC_TICK, 32'd432, 4'd0, 1'b0, 32'sd0, 8'd0, 8'd0);
      offer(FUNC_TICK, 32'd632, 4'd0, 1'b0, 32'sd0, 8'd0, 8'd0);
      offer(FUNC_TICK, 32'd832, 4'd0, 1'b0, 32'sd0, 8'd0, 8'd0);
      offer(FUNC_TICK, 32'd1032, 4'd0, 1'b0, 32'sd0, 8'd0, 8'd0);
      offer(FUNC_TICK, 32'd5000, 4'd0, 1'b0, 32'sd0, 8'd0, 8'd0);
      offer(FUNC_UNUSED, 32'hFFFFFFFF, 4'd0, 1'b0, 32'sd0, 8'd0, 8'd0);

      now_ms      = 32'hFFFFFFFF;
      last_status = 8'd2;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin
               ack_cfg = 16'd1; retry_cfg = 4'd0; poll_cfg = 16'd1; link_cfg = 16'd1;
            end
            1: begin
               ack_cfg = 16'hFFFF; retry_cfg = 4'd15; poll_cfg = 16'hFFFF; link_cfg = 16'hFFFF;
            end
            2: begin
               ack_cfg = 16'd0; retry_cfg = 4'd15; poll_cfg = 16'd0; link_cfg = 16'd0;
            end
            default: begin
               ack_cfg   = $urandom_range(1, 80);
               retry_cfg = $urandom_range(0, 15);
               poll_cfg  = $urandom_range(1, 80);
               link_cfg  = $urandom_range(1, 300);
            end
         endcase
         configure(ack_cfg, retry_cfg, poll_cfg, link_cfg);
         calm <= (phase == 6);
         if ($urandom_range(3) == 0) now_ms = 32'hFFFFFFFF - $urandom_range(0, 2000);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if ((phase == 4 || phase == 9) && n == 20) hold_tickets <= hold_tickets + 1;
            if (phase == 5 && n == 75) drain();
            pick   = $urandom_range(99);
            now_ms = now_ms + ((pick < 3) ? $urandom() : $urandom_range(0, ack_cfg / 3 + 2));
            pick   = $urandom_range(99);
            if (pick < 30) func_sel = FUNC_ENQUEUE;
            else if (pick < 55) func_sel = FUNC_STATUS;
            else if (pick < 97) func_sel = FUNC_TICK;
            else func_sel = FUNC_UNUSED;
            sseq = ($urandom_range(1) == 0) ? last_status : 8'($urandom_range(255));
            aseq = ($urandom_range(99) < 60) ? flight_sequence : 8'($urandom_range(255));
            if (func_sel == FUNC_STATUS) last_status = sseq;
            offer(func_sel, now_ms, 4'($urandom_range(15)), 1'($urandom_range(1)),
                  $urandom(), sseq, aseq);
         end
      end

      drain();
      repeat (10) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// File: filelist.f
rtl/core/slk_pkg.sv
rtl/core/slk_req_if.sv
rtl/core/slk_rsp_if.sv
rtl/core/slk_csr_if.sv
rtl/core/slk_front.sv
rtl/core/slk_back.sv
rtl/core/stop_and_wait_command_link.sv
bench/slk_result_checker.sv
bench/stop_and_wait_command_link_tb.sv
